@@ rtl/bpu_pkg.sv @@
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared constants and types of the bit-plane to pixel count unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

   localparam int DEFAULT_ROWS       = 256;
   localparam int DEFAULT_COLUMNS    = 256;
   localparam int DEFAULT_BIT_PLANES = 14;

   localparam int BYTE_W          = 8;
   localparam int COUNT_W         = 14;
   localparam int ROW_W           = 8;
   localparam int COLUMN_W        = 8;
   localparam int PIXELS_PER_BYTE = 8;
   localparam int PIXEL_IDX_W     = 3;

   localparam logic [PIXEL_IDX_W-1:0] LAST_PIXEL = PIXEL_IDX_W'(PIXELS_PER_BYTE - 1);

   // Position of one final-plane byte, carried with its eight pixels
   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] col_base;
      logic                last_frame;
   } run_info_type;

endpackage

@@ rtl/bpu_if.sv @@
// ----------------------------------------------------------------------------
// bpu_if
// Request and response channels of the bit-plane to pixel count unpacker.
// ----------------------------------------------------------------------------
interface bpu_req_if;
   logic                       valid;
   logic                       ready;
   logic [bpu_pkg::BYTE_W-1:0] raw_byte;
   logic                       frame_start;

   modport source (output valid, output raw_byte, output frame_start, input ready);
   modport sink   (input valid, input raw_byte, input frame_start, output ready);
endinterface

interface bpu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bpu_pkg::COUNT_W-1:0]  pixel_count;
   logic [bpu_pkg::ROW_W-1:0]    pixel_row;
   logic [bpu_pkg::COLUMN_W-1:0] pixel_column;
   logic                         run_last;
   logic                         frame_done;

   modport source (output valid, output pixel_count, output pixel_row, output pixel_column,
                   output run_last, output frame_done, input ready);
   modport sink   (input valid, input pixel_count, input pixel_row, input pixel_column,
                   input run_last, input frame_done, output ready);
endinterface

@@ rtl/bpu_ram.sv @@
// ----------------------------------------------------------------------------
// bpu_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bitplane_to_pixel_count_unpacker_top.sv @@
// ----------------------------------------------------------------------------
// bitplane_to_pixel_count_unpacker_top
// Corner turn of a bit-plane ordered readout into per-pixel counts.
// ----------------------------------------------------------------------------
// Each request carries one readout byte; bytes arrive by row, then bit plane,
// then byte column. Bytes of every plane but the last are written into one
// RAM per plane (COLUMNS/8 entries each) and are taken one per cycle. A byte
// of the final plane reads all plane RAMs at its byte column, and eight pixel
// responses follow in ascending column order through the read stage and the
// pixel emitter. The single response port paces final-plane bytes: a new one
// loads only once the last pixel of the one before is taken. One such byte may
// wait in the read stage while the previous eight pixels drain; while it
// waits, the request port is held off, so any byte behind it, stored plane
// or not, waits as well. The plane RAMs need no clearing: each entry is
// written before it is read in a well-ordered stream. frame_start clears
// the row, plane and column positions before its byte is placed.
// ----------------------------------------------------------------------------
module bitplane_to_pixel_count_unpacker_top #(
   parameter int ROWS       = bpu_pkg::DEFAULT_ROWS,
   parameter int COLUMNS    = bpu_pkg::DEFAULT_COLUMNS,
   parameter int BIT_PLANES = bpu_pkg::DEFAULT_BIT_PLANES
) (
   input  logic      clock,
   input  logic      reset,
   bpu_req_if.sink   req_chan,
   bpu_rsp_if.source rsp_chan
);

   localparam int BYTE_COLS     = COLUMNS / 8;
   localparam int STORED_PLANES = BIT_PLANES - 1;
   localparam int LANES         = (STORED_PLANES > 0) ? STORED_PLANES : 1;
   localparam int BC_W          = (BYTE_COLS > 1) ? $clog2(BYTE_COLS) : 1;
   localparam int PL_W          = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
   localparam int RW_W          = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int W_EXT         = (BC_W > 5) ? BC_W : 5;
   localparam int ROW_EXT       = (RW_W > bpu_pkg::ROW_W) ? RW_W : bpu_pkg::ROW_W;
   localparam int VAL_W         = (BIT_PLANES > bpu_pkg::COUNT_W) ? BIT_PLANES
                                                                  : bpu_pkg::COUNT_W;

   localparam logic [BC_W-1:0] LAST_COL   = BC_W'(BYTE_COLS - 1);
   localparam logic [PL_W-1:0] LAST_PLANE = PL_W'(BIT_PLANES - 1);
   localparam logic [RW_W-1:0] LAST_ROW   = RW_W'(ROWS - 1);
   localparam logic [bpu_pkg::COLUMN_W-1:0] COL_LO = bpu_pkg::COLUMN_W'(COLUMNS % 256);

   // Position counters
   logic [BC_W-1:0] col_ff,   col_in;
   logic [PL_W-1:0] plane_ff, plane_in;
   logic [RW_W-1:0] row_ff,   row_in;

   logic [BC_W-1:0] cur_col;
   logic [PL_W-1:0] cur_plane;
   logic [RW_W-1:0] cur_row;
   logic            req_fire;
   logic            is_final;
   logic [W_EXT-1:0]   col_ext;
   logic [ROW_EXT-1:0] row_ext;
   bpu_pkg::run_info_type cur_info;

   // Read stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [bpu_pkg::BYTE_W-1:0]    s1_byte_ff;
   bpu_pkg::run_info_type         s1_info_ff;
   logic [bpu_pkg::BYTE_W-1:0]    plane_data [LANES];
   logic [bpu_pkg::COUNT_W-1:0]   s1_counts [bpu_pkg::PIXELS_PER_BYTE];

   // Pixel emitter
   logic                             emit_valid_ff, emit_valid_in;
   logic [bpu_pkg::PIXEL_IDX_W-1:0]  emit_k_ff, emit_k_in;
   logic [bpu_pkg::COUNT_W-1:0]      emit_count_ff [bpu_pkg::PIXELS_PER_BYTE];
   bpu_pkg::run_info_type            emit_info_ff;
   logic                             rsp_fire;
   logic                             emit_last;
   logic                             load_ok;

   assign emit_last = emit_k_ff == bpu_pkg::LAST_PIXEL;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign load_ok   = !emit_valid_ff || (emit_last && rsp_chan.ready);

   assign req_chan.ready = !s1_valid_ff || load_ok;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      cur_col   = req_chan.frame_start ? '0 : col_ff;
      cur_plane = req_chan.frame_start ? '0 : plane_ff;
      cur_row   = req_chan.frame_start ? '0 : row_ff;
      is_final  = cur_plane == LAST_PLANE;

      col_in   = col_ff;
      plane_in = plane_ff;
      row_in   = row_ff;
      if (req_fire) begin
         col_in   = cur_col + BC_W'(1);
         plane_in = cur_plane;
         row_in   = cur_row;
         if (cur_col == LAST_COL) begin
            col_in   = '0;
            plane_in = cur_plane + PL_W'(1);
            if (is_final) begin
               plane_in = '0;
               row_in   = cur_row + RW_W'(1);
               if (cur_row == LAST_ROW) begin
                  row_in = '0;
               end
            end
         end
      end

      // Column COLUMNS-8-8w, kept to its low byte
      col_ext  = W_EXT'(cur_col);
      row_ext  = ROW_EXT'(cur_row);
      cur_info.row        = row_ext[bpu_pkg::ROW_W-1:0];
      cur_info.col_base   = COL_LO - bpu_pkg::COLUMN_W'(8) - {col_ext[4:0], 3'b000};
      cur_info.last_frame = (cur_row == LAST_ROW) && (cur_col == LAST_COL);
   end

   // One RAM per stored plane, all read together for a final-plane byte
   for (genvar i = 0; i < LANES; i++) begin : g_plane
      if (i < STORED_PLANES) begin : g_ram
         bpu_ram #(
            .WIDTH (bpu_pkg::BYTE_W),
            .DEPTH (BYTE_COLS)
         ) u_ram (
            .clock   (clock),
            .wr_en   (req_fire && !is_final && (cur_plane == PL_W'(i))),
            .wr_addr (cur_col),
            .wr_data (req_chan.raw_byte),
            .rd_en   (req_fire && is_final),
            .rd_addr (cur_col),
            .rd_data (plane_data[i])
         );
      end else begin : g_none
         assign plane_data[i] = '0;
      end
   end

   // Transpose: bit k of plane p lands in bit BIT_PLANES-1-p of pixel k
   always_comb begin
      logic [VAL_W-1:0] val;
      for (int k = 0; k < bpu_pkg::PIXELS_PER_BYTE; k++) begin
         val    = '0;
         val[0] = s1_byte_ff[k];
         for (int p = 0; p < STORED_PLANES; p++) begin
            val[BIT_PLANES - 1 - p] = plane_data[p][k];
         end
         s1_counts[k] = val[bpu_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire && is_final) begin
         s1_valid_in = 1'b1;
      end else if (load_ok) begin
         s1_valid_in = 1'b0;
      end

      emit_valid_in = emit_valid_ff;
      emit_k_in     = emit_k_ff;
      if (load_ok && s1_valid_ff) begin
         emit_valid_in = 1'b1;
         emit_k_in     = '0;
      end else if (rsp_fire) begin
         if (emit_last) begin
            emit_valid_in = 1'b0;
         end else begin
            emit_k_in = emit_k_ff + bpu_pkg::PIXEL_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         plane_ff      <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         emit_valid_ff <= 1'b0;
         emit_k_ff     <= '0;
      end else begin
         col_ff        <= col_in;
         plane_ff      <= plane_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         emit_valid_ff <= emit_valid_in;
         emit_k_ff     <= emit_k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_final) begin
         s1_byte_ff <= req_chan.raw_byte;
         s1_info_ff <= cur_info;
      end
      if (load_ok && s1_valid_ff) begin
         emit_count_ff <= s1_counts;
         emit_info_ff  <= s1_info_ff;
      end
   end

   assign rsp_chan.valid        = emit_valid_ff;
   assign rsp_chan.pixel_count  = emit_count_ff[emit_k_ff];
   assign rsp_chan.pixel_row    = emit_info_ff.row;
   assign rsp_chan.pixel_column = emit_info_ff.col_base + bpu_pkg::COLUMN_W'(emit_k_ff);
   assign rsp_chan.run_last     = emit_last;
   assign rsp_chan.frame_done   = emit_last && emit_info_ff.last_frame;

   a_final_reaches_read_stage : assert property (
      @(posedge clock) disable iff (reset)
      (req_fire && is_final) |=> s1_valid_ff
   ) else $error("final-plane request did not reach the read stage");

   a_load_starts_run : assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && load_ok) |=> (emit_valid_ff && emit_k_ff == '0)
   ) else $error("emitter did not start a new run after load");

   a_run_advances : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_fire && !emit_last) |=>
         (emit_valid_ff && emit_k_ff == $past(emit_k_ff) + bpu_pkg::PIXEL_IDX_W'(1))
   ) else $error("pixel index did not step after response");

   a_frame_done_on_last : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_done) |-> rsp_chan.run_last
   ) else $error("frame end flagged away from the last pixel of a run");

endmodule
